>>> src/tun_pkg.sv
// Package: shared types and constants for the triangle unit normal pipeline.
package tun_pkg;

  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned OutFracBits  = 14;
  localparam int unsigned OutWidth     = 16;

  typedef struct packed {
    logic signed [CoordWidth-1:0] ax;
    logic signed [CoordWidth-1:0] ay;
    logic signed [CoordWidth-1:0] az;
    logic signed [CoordWidth-1:0] bx;
    logic signed [CoordWidth-1:0] by;
    logic signed [CoordWidth-1:0] bz;
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic signed [CoordWidth-1:0] cz;
  } tri_in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] normal_x;
    logic signed [OutWidth-1:0] normal_y;
    logic signed [OutWidth-1:0] normal_z;
    logic                       degenerate;
  } norm_out_t;

endpackage

>>> src/tun_front.sv
// Front stages: edge vectors, cross product, squared magnitudes.
module tun_front #(
  parameter int unsigned CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [9*CW-1:0]       coords_i,
  output logic                  valid_o,
  output logic [2*CW+2:0]       nx_o,
  output logic [2*CW+2:0]       ny_o,
  output logic [2*CW+2:0]       nz_o,
  output logic [4*CW+5:0]       sumsq_o
);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned NW = 2 * CW + 3;
  localparam int unsigned MW = NW - 1;
  localparam int unsigned SW = 4 * CW + 6;

  logic signed [CW-1:0] c [9];
  logic signed [EW-1:0] e_d [6];
  logic signed [EW-1:0] e_q [6];
  logic signed [PW-1:0] p_d [6];
  logic signed [PW-1:0] p_q [6];
  logic signed [NW-1:0] n_d [3];
  logic signed [NW-1:0] n_q [3];
  logic [MW-1:0]        m_d [3];
  logic [SW-1:0]        sq_d [3];
  logic [SW-1:0]        sq_q [3];
  logic signed [NW-1:0] n2_q [3];
  logic [SW-1:0]        s_d;
  logic [SW-1:0]        s_q;
  logic signed [NW-1:0] n3_q [3];
  logic [4:0]           v_q;

  // corner unpack, first corner in the top bits
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      c[i] = coords_i[(8-i)*CW +: CW];
    end
  end

  // edges e1 = b - a, e2 = c - a
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_d[i]   = EW'(c[3+i]) - EW'(c[i]);
      e_d[3+i] = EW'(c[6+i]) - EW'(c[i]);
    end
  end

  // six partial products of the cross product
  always_comb begin
    p_d[0] = e_q[1] * e_q[5];
    p_d[1] = e_q[2] * e_q[4];
    p_d[2] = e_q[2] * e_q[3];
    p_d[3] = e_q[0] * e_q[5];
    p_d[4] = e_q[0] * e_q[4];
    p_d[5] = e_q[1] * e_q[3];
  end

  // cross components and their squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = NW'(p_q[2*i]) - NW'(p_q[2*i+1]);
    end
    for (int i = 0; i < 3; i++) begin
      m_d[i]  = n_q[i][NW-1] ? MW'(-n_q[i]) : MW'(n_q[i]);
      sq_d[i] = SW'(m_d[i]) * SW'(m_d[i]);
    end
    s_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  // valid bits, one per data stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    e_q  <= e_d;
    p_q  <= p_d;
    n_q  <= n_d;
    sq_q <= sq_d;
    n2_q <= n_q;
    s_q  <= s_d;
    n3_q <= n2_q;
  end

  assign valid_o = v_q[4];
  assign nx_o    = n3_q[0];
  assign ny_o    = n3_q[1];
  assign nz_o    = n3_q[2];
  assign sumsq_o = s_q;
endmodule

>>> src/tun_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module tun_sqrt #(
  parameter int unsigned CW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [4*CW+5:0]   rad_i,
  input  logic [2*CW+2:0]   nx_i,
  input  logic [2*CW+2:0]   ny_i,
  input  logic [2*CW+2:0]   nz_i,
  output logic              valid_o,
  output logic [2*CW+2:0]   root_o,
  output logic              zero_o,
  output logic [2*CW+2:0]   nx_o,
  output logic [2*CW+2:0]   ny_o,
  output logic [2*CW+2:0]   nz_o
);
  localparam int unsigned SW = 4 * CW + 6;
  localparam int unsigned RW = SW / 2;
  localparam int unsigned NW = 2 * CW + 3;

  // nonrestoring-free digit recurrence: rem, root per stage
  logic [SW-1:0] rad_q  [1:RW];
  logic [SW+1:0] rem_q  [1:RW];
  logic [RW-1:0] root_q [1:RW];
  logic [NW-1:0] x_q [1:RW];
  logic [NW-1:0] y_q [1:RW];
  logic [NW-1:0] z_q [1:RW];
  logic          z0_q [1:RW];
  logic [RW:1]   v_q;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [SW-1:0] rad_in;
    logic [SW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [NW-1:0] x_in, y_in, z_in;
    logic          z0_in, v_in;
    logic [SW+1:0] rem_sh;
    logic [SW+1:0] trial;
    // stage input: ports for the first stage, previous registers after
    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = nx_i;
      assign y_in    = ny_i;
      assign z_in    = nz_i;
      assign z0_in   = (rad_i == '0);
      assign v_in    = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[s];
      assign rem_in  = rem_q[s];
      assign root_in = root_q[s];
      assign x_in    = x_q[s];
      assign y_in    = y_q[s];
      assign z_in    = z_q[s];
      assign z0_in   = z0_q[s];
      assign v_in    = v_q[s];
    end
    always_comb begin
      rem_sh = {rem_in[SW-1:0], rad_in[SW-1 -: 2]};
      trial  = {{(SW-RW){1'b0}}, root_in, 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1] <= rad_in << 2;
      if (rem_sh >= trial) begin
        rem_q[s+1]  <= rem_sh - trial;
        root_q[s+1] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_q[s+1]  <= rem_sh;
        root_q[s+1] <= {root_in[RW-2:0], 1'b0};
      end
      x_q[s+1]  <= x_in;
      y_q[s+1]  <= y_in;
      z_q[s+1]  <= z_in;
      z0_q[s+1] <= z0_in;
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = NW'(root_q[RW]);
  assign zero_o  = z0_q[RW];
  assign nx_o    = x_q[RW];
  assign ny_o    = y_q[RW];
  assign nz_o    = z_q[RW];
endmodule

>>> src/tun_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module tun_div #(
  parameter int unsigned CW  = 16,
  parameter int unsigned OFB = 14,
  parameter int unsigned OW  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2*CW+2:0]   den_i,
  input  logic              zero_i,
  input  logic [2*CW+2:0]   nx_i,
  input  logic [2*CW+2:0]   ny_i,
  input  logic [2*CW+2:0]   nz_i,
  output logic              valid_o,
  output logic [3*OW:0]     res_o
);
  localparam int unsigned NW = 2 * CW + 3;
  localparam int unsigned MW = NW - 1;
  // quotient never exceeds 2^OFB: OFB+1 bits
  localparam int unsigned QW = OFB + 1;
  localparam int unsigned DW = MW + OFB;

  logic [DW-1:0] num0 [3];
  logic [NW:0]   rem0 [3];
  logic          sgn0 [3];
  logic [DW-1:0] num_q [3][1:QW];
  logic [NW:0]   rem_q [3][1:QW];
  logic [QW-1:0] quo_q [3][1:QW];
  logic          sgn_q [3][1:QW];
  logic [NW-1:0] den_q [1:QW];
  logic          z_q   [1:QW];
  logic [QW:1]   v_q;
  logic [NW-1:0] nin [3];

  assign nin[0] = nx_i;
  assign nin[1] = ny_i;
  assign nin[2] = nz_i;

  // leading zero-quotient bits: numerator top (DW-QW) bits lie below den
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [MW-1:0] mag;
      logic [DW-1:0] full;
      mag     = nin[l][NW-1] ? MW'(-nin[l]) : MW'(nin[l]);
      full    = {mag, {OFB{1'b0}}};
      num0[l] = full << (DW - QW);
      rem0[l] = (NW+1)'(full >> QW);
      sgn0[l] = nin[l][NW-1];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] den_in;
    logic          z_in, v_in;
    // stage input: ports for the first stage, previous registers after
    if (s == 0) begin : g_first
      assign den_in = den_i;
      assign z_in   = zero_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign den_in = den_q[s];
      assign z_in   = z_q[s];
      assign v_in   = v_q[s];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_in;
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW-1:0] num_in;
      logic [NW:0]   rem_in;
      logic [QW-1:0] quo_in;
      logic          sgn_in;
      logic [NW:0]   rsh;
      if (s == 0) begin : g_first
        assign num_in = num0[l];
        assign rem_in = rem0[l];
        assign quo_in = '0;
        assign sgn_in = sgn0[l];
      end else begin : g_next
        assign num_in = num_q[l][s];
        assign rem_in = rem_q[l][s];
        assign quo_in = quo_q[l][s];
        assign sgn_in = sgn_q[l][s];
      end
      assign rsh = {rem_in[NW-1:0], num_in[DW-1]};
      always_ff @(posedge clk_i) begin
        num_q[l][s+1] <= num_in << 1;
        sgn_q[l][s+1] <= sgn_in;
        if (rsh >= {1'b0, den_in}) begin
          rem_q[l][s+1] <= rsh - {1'b0, den_in};
          quo_q[l][s+1] <= {quo_in[QW-2:0], 1'b1};
        end else begin
          rem_q[l][s+1] <= rsh;
          quo_q[l][s+1] <= {quo_in[QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_in;
      z_q[s+1]   <= z_in;
    end
  end

  // sign restore and degenerate override
  logic [OW-1:0] comp [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [OW-1:0] qv;
      qv = OW'(quo_q[l][QW]);
      comp[l] = z_q[QW] ? '0 : (sgn_q[l][QW] ? -qv : qv);
    end
  end

  assign valid_o = v_q[QW];
  assign res_o   = {comp[0], comp[1], comp[2], z_q[QW]};
endmodule

>>> src/triangle_unit_normal_unit.sv
// Pipeline order: front stages, square-root stages, divider stages, output register.
// Throughput: one triangle word per cycle; busy is tied low, no stalls.
// The depth is set by the square-root stages, one root bit each, and the
// divider stages, one quotient bit each. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; no word is lost
// or invented across reset release.
module triangle_unit_normal_unit #(
  parameter int unsigned COORD_WIDTH   = tun_pkg::CoordWidth,
  parameter int unsigned OUT_FRAC_BITS = tun_pkg::OutFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tun_pkg::tri_in_t   tri_i,
  output logic               done_o,
  output tun_pkg::norm_out_t norm_o
);
  import tun_pkg::*;

  localparam int unsigned NW = 2 * COORD_WIDTH + 3;
  localparam int unsigned SW = 4 * COORD_WIDTH + 6;

  logic          f_v, s_v, d_v, zero;
  logic [NW-1:0] fx, fy, fz, sx, sy, sz, root;
  logic [SW-1:0] sumsq;
  logic [3*OutWidth:0] res;
  logic          out_v_q;
  norm_out_t     out_q;
  logic [9*COORD_WIDTH-1:0] coords;

  assign busy = 1'b0;

  // corners, each sign-extended to the internal coordinate width
  assign coords = {COORD_WIDTH'(tri_i.ax), COORD_WIDTH'(tri_i.ay), COORD_WIDTH'(tri_i.az),
                   COORD_WIDTH'(tri_i.bx), COORD_WIDTH'(tri_i.by), COORD_WIDTH'(tri_i.bz),
                   COORD_WIDTH'(tri_i.cx), COORD_WIDTH'(tri_i.cy), COORD_WIDTH'(tri_i.cz)};

  tun_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i(start), .coords_i(coords),
    .valid_o(f_v), .nx_o(fx), .ny_o(fy), .nz_o(fz), .sumsq_o(sumsq)
  );

  tun_sqrt #(.CW(COORD_WIDTH)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(f_v), .rad_i(sumsq), .nx_i(fx), .ny_i(fy),
    .nz_i(fz), .valid_o(s_v), .root_o(root), .zero_o(zero), .nx_o(sx),
    .ny_o(sy), .nz_o(sz)
  );

  tun_div #(.CW(COORD_WIDTH), .OFB(OUT_FRAC_BITS), .OW(OutWidth)) u_div (
    .clk_i, .rst_ni, .valid_i(s_v), .den_i(root), .zero_i(zero),
    .nx_i(sx), .ny_i(sy), .nz_i(sz), .valid_o(d_v), .res_o(res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= norm_out_t'(res);
  end

  assign done_o = out_v_q;
  assign norm_o = out_q;
endmodule

>>> src/tun_checker.sv
// Port checker for the unit normal pipeline, bound to the top level.
module tun_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input tun_pkg::norm_out_t norm_o
);
  import tun_pkg::*;

  localparam int unsigned Lat = 5 + 35 + 15 + 1;

  // fixed latency: every accepted word gives one done
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o) else $error("missing result");

  // degenerate word carries a zero normal
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && norm_o.degenerate) |-> (norm_o.normal_x == '0 &&
      norm_o.normal_y == '0 && norm_o.normal_z == '0))
    else $error("degenerate with nonzero normal");

  // x magnitude stays within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(norm_o.normal_x) <= 16384 &&
      $signed(norm_o.normal_x) >= -16384))
    else $error("normal out of range");

  // no result without an earlier start
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat)) else $error("result without start");
endmodule

bind triangle_unit_normal_unit tun_checker u_tun_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .norm_o
);

>>> test/testbench.sv
// Testbench for triangle_unit_normal_unit: directed table plus random triangles vs. a predictor.
`timescale 1ns / 1ps

module testbench;
  import tun_pkg::*;

  localparam int NumRandom = 950;
  localparam int DrainCycles = 70;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  tri_in_t   tri_i;
  logic      done_o;
  norm_out_t norm_o;

  triangle_unit_normal_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .tri_i (tri_i),
    .done_o(done_o),
    .norm_o(norm_o)
  );

  // Directed row: triangle, plus an expected word where it is obvious.
  typedef struct {
    tri_in_t   corners;
    bit        known;
    norm_out_t want;
  } tri_row_t;

  norm_out_t normal_q[$];
  norm_out_t known_q[$];
  bit        known_flag_q[$];
  int        fail_cnt;
  int        word_cnt;
  int        degen_cnt;
  bit        no_idle;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Exact unit normal: cross product of the edges, floor root, truncated quotient.
  function automatic norm_out_t unit_normal(tri_in_t t);
    longint    e1x, e1y, e1z, e2x, e2y, e2z;
    longint    n[3];
    logic [127:0] sum_sq, cand, len, mag, quot;
    norm_out_t res;
    e1x = longint'(t.bx) - longint'(t.ax);
    e1y = longint'(t.by) - longint'(t.ay);
    e1z = longint'(t.bz) - longint'(t.az);
    e2x = longint'(t.cx) - longint'(t.ax);
    e2y = longint'(t.cy) - longint'(t.ay);
    e2z = longint'(t.cz) - longint'(t.az);
    n[0] = e1y * e2z - e1z * e2y;
    n[1] = e1z * e2x - e1x * e2z;
    n[2] = e1x * e2y - e1y * e2x;
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
      sum_sq += mag * mag;
    end
    res = '0;
    if (sum_sq == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    len = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = len | (128'(1) << b);
      if (cand * cand <= sum_sq) len = cand;
    end
    for (int i = 0; i < 3; i++) begin
      mag  = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
      quot = (mag << OutFracBits) / len;
      if (n[i] < 0) quot = -quot;
      case (i)
        0: res.normal_x = quot[OutWidth-1:0];
        1: res.normal_y = quot[OutWidth-1:0];
        default: res.normal_z = quot[OutWidth-1:0];
      endcase
    end
    return res;
  endfunction

  function automatic tri_in_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz);
    tri_in_t t;
    t.ax = CoordWidth'(ax); t.ay = CoordWidth'(ay); t.az = CoordWidth'(az);
    t.bx = CoordWidth'(bx); t.by = CoordWidth'(by); t.bz = CoordWidth'(bz);
    t.cx = CoordWidth'(cx); t.cy = CoordWidth'(cy); t.cz = CoordWidth'(cz);
    return t;
  endfunction

  function automatic norm_out_t mk_norm(int x, int y, int z, bit dg);
    norm_out_t r;
    r.normal_x = OutWidth'(x); r.normal_y = OutWidth'(y); r.normal_z = OutWidth'(z);
    r.degenerate = dg;
    return r;
  endfunction

  function automatic logic [CoordWidth-1:0] small_coord();
    return CoordWidth'($urandom_range(0, 511) - 256);
  endfunction

  // Random triangle; flavor picks full range, small, degenerate or axis-aligned.
  function automatic tri_in_t rand_tri();
    tri_in_t t;
    int      sel, k;
    t = tri_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      t.ax = small_coord(); t.ay = small_coord(); t.az = small_coord();
      t.bx = small_coord(); t.by = small_coord(); t.bz = small_coord();
      t.cx = small_coord(); t.cy = small_coord(); t.cz = small_coord();
    end else if (sel < 5) begin
      // collinear: c = a + k*(b - a), small edge; cx is sometimes nudged off the line
      k = $urandom_range(0, 6) - 3;
      t.bx = CoordWidth'(t.ax + $urandom_range(0, 200) - 100);
      t.by = CoordWidth'(t.ay + $urandom_range(0, 200) - 100);
      t.bz = CoordWidth'(t.az + $urandom_range(0, 200) - 100);
      t.cx = CoordWidth'(t.ax + k * (t.bx - t.ax));
      t.cy = CoordWidth'(t.ay + k * (t.by - t.ay));
      t.cz = CoordWidth'(t.az + k * (t.bz - t.az));
      if ($urandom_range(0, 3) == 0) t.cx = CoordWidth'(t.cx + 1);
    end else if (sel == 5) begin
      t.bz = t.az;
      t.cz = t.az;
    end
    return t;
  endfunction

  // Present one word and hold it until accepted.
  task automatic send_word(tri_in_t t);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    tri_i <= t;
    do @(posedge clk_i); while (busy);
  endtask

  // Acceptance and result check, both sampled at the rising edge.
  always @(posedge clk_i) begin
    norm_out_t want;
    if (rst_ni && start && !busy) normal_q.push_back(unit_normal(tri_i));
    if (rst_ni && done_o) begin
      word_cnt++;
      if (norm_o.degenerate) degen_cnt++;
      if (normal_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        want = normal_q.pop_front();
        if (norm_o.normal_x !== want.normal_x) begin
          $error("normal_x exp %0d got %0d", want.normal_x, norm_o.normal_x); fail_cnt++;
        end
        if (norm_o.normal_y !== want.normal_y) begin
          $error("normal_y exp %0d got %0d", want.normal_y, norm_o.normal_y); fail_cnt++;
        end
        if (norm_o.normal_z !== want.normal_z) begin
          $error("normal_z exp %0d got %0d", want.normal_z, norm_o.normal_z); fail_cnt++;
        end
        if (norm_o.degenerate !== want.degenerate) begin
          $error("degenerate exp %0d got %0d", want.degenerate, norm_o.degenerate);
          fail_cnt++;
        end
        if (known_q.size() != 0) begin
          if (known_flag_q[0] && norm_o !== known_q[0]) begin
            $error("directed row mismatch exp %h got %h", known_q[0], norm_o); fail_cnt++;
          end
          void'(known_q.pop_front());
          void'(known_flag_q.pop_front());
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAIL triangle_unit_normal_unit");
    $finish;
  end

  initial begin
    tri_row_t rows[$];
    int       waited;
    start    = 1'b0;
    tri_i    = '0;
    rst_ni   = 1'b0;
    fail_cnt = 0;
    no_idle  = 1'b0;
    word_cnt = 0;
    degen_cnt = 0;

    // Directed rows: zero, unit axes, coincident, collinear, extremes.
    rows.push_back('{mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_norm(0, 0, 0, 1)});
    rows.push_back('{mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, mk_norm(0, 0, 16384, 0)});
    rows.push_back('{mk_tri(0, 0, 0, 0, 1, 0, 1, 0, 0), 1, mk_norm(0, 0, -16384, 0)});
    rows.push_back('{mk_tri(0, 0, 0, 0, 1, 0, 0, 0, 1), 1, mk_norm(16384, 0, 0, 0)});
    rows.push_back('{mk_tri(0, 0, 0, 0, 0, 1, 1, 0, 0), 1, mk_norm(0, 16384, 0, 0)});
    rows.push_back('{mk_tri(5, 6, 7, 5, 6, 7, 5, 6, 7), 1, mk_norm(0, 0, 0, 1)});
    rows.push_back('{mk_tri(1, 1, 1, 2, 2, 2, 3, 3, 3), 1, mk_norm(0, 0, 0, 1)});
    rows.push_back('{mk_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                            -32768, -32768, -32768), 1, mk_norm(0, 0, 0, 1)});
    rows.push_back('{mk_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                            -32768, 32767, -32768), 1, mk_norm(0, 0, 16384, 0)});
    rows.push_back('{mk_tri(32767, 32767, 32767, -32768, 32767, 32767,
                            32767, -32768, 32767), 1, mk_norm(0, 0, 16384, 0)});
    rows.push_back('{mk_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                            32767, 32767, -32768), 0, '0});
    rows.push_back('{mk_tri(32767, -32768, 32767, -32768, 32767, -32768,
                            -32768, -32768, 32767), 0, '0});
    rows.push_back('{mk_tri(0, 0, 0, 1, 1, 1, 1, -1, 0), 0, '0});
    rows.push_back('{mk_tri(100, -200, 300, -400, 500, -600, 700, 800, -900), 0, '0});
    rows.push_back('{mk_tri(0, 0, 0, 32767, 1, 0, 0, 1, 32767), 0, '0});
    rows.push_back('{mk_tri(-1, -1, -1, 0, 0, 0, -1, 0, -1), 0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      known_q.push_back(rows[i].want);
      known_flag_q.push_back(rows[i].known);
      send_word(rows[i].corners);
    end

    for (int i = 0; i < NumRandom; i++) begin
      no_idle = (i >= 300 && i < 450);
      if (i == 600) begin
        // hold off until the pipeline has drained completely
        start <= 1'b0;
        do @(posedge clk_i); while (normal_q.size() != 0);
      end
      send_word(rand_tri());
    end
    start <= 1'b0;

    waited = 0;
    while (normal_q.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (normal_q.size() != 0) begin
      $error("%0d expected words never arrived", normal_q.size());
      fail_cnt++;
    end

    $display("Checked %0d normal words (%0d degenerate) from directed and random triangles,",
             word_cnt, degen_cnt);
    $display("including full-range corners, collinear sets and a drained pause.");
    if (fail_cnt == 0) begin
      $display("PASS triangle_unit_normal_unit");
    end else begin
      $display("FAIL triangle_unit_normal_unit");
    end
    $finish;
  end

endmodule

>>> files.f
src/tun_pkg.sv
src/tun_front.sv
src/tun_sqrt.sv
src/tun_div.sv
src/triangle_unit_normal_unit.sv
src/tun_checker.sv
test/testbench.sv
